/* hdl/ogb_pkg.sv */
// Shared types and constants for the occupancy grid box update block.
package ogb_pkg;

  localparam int CELL_W   = 8;
  localparam int COORD_W  = 10;  // one bit over the 9-bit fields, holds x + half width
  localparam int FIELD_W  = 9;
  localparam int WEIGHT_W = 6;
  localparam int HALF_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CELL_W-1:0] CELL_UNKNOWN = 8'hFF;
  localparam logic [CELL_W-1:0] CELL_FREE    = 8'h00;
  localparam logic [CELL_W-1:0] CELL_ROBOT   = 8'h01;
  localparam logic signed [CELL_W-1:0] LEVEL_MAX = 8'sd127;

  localparam logic ACT_SENSOR = 1'b0;
  localparam logic ACT_POSE   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HIT_WEIGHT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_HEIGHT = 2'd2;

  localparam logic [WEIGHT_W-1:0] HIT_WEIGHT_RST = 6'd5;
  localparam logic [HALF_W-1:0]   HALF_RST       = 4'd5;

  typedef struct packed {
    logic               action;
    logic [FIELD_W-1:0] cell_x;
    logic [FIELD_W-1:0] cell_y;
    logic [FIELD_W-1:0] origin_x;
    logic [FIELD_W-1:0] origin_y;
  } in_item_t;

  typedef struct packed {
    logic signed [CELL_W-1:0] hit_level;
    logic                     footprint_stamped;
  } out_item_t;

  // Walk command: load bounds and start.
  typedef struct packed {
    logic               start;
    logic [COORD_W-1:0] x_lo;
    logic [COORD_W-1:0] x_hi;
    logic [COORD_W-1:0] y_lo;
    logic [COORD_W-1:0] y_hi;
  } walk_cmd_t;

  // Current cell of the walk.
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } walk_pos_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_WALK  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

/* hdl/occupancy_grid_box_update.sv */
// Top level of the occupancy grid box update block.
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------
//  in       | in_valid / in_ready    | in_data  (ogb_pkg::in_item_t)
//  out      | out_valid / out_ready  | out_data (ogb_pkg::out_item_t)
//  cfg      | cfg_en, no wait        | cfg_index, cfg_data
//
// Walk: a sensor item visits every cell of the box from hit to origin, one read-modify-write a cycle;
// a moved pose stamps its footprint box, clipped below zero; an unmoved pose walks no cells.
// Cells past the far map edges are still stepped through, but not read or written.
// Reset: a clearing pass writes every one of the 2**(XW+YW) cells to unknown (262144 at
// 512 x 512), with in_ready low; configuration writes are taken throughout.
// Stalls: a stalled out_ready holds the next item's result until the register frees up.
module occupancy_grid_box_update #(
  parameter int MAP_WIDTH  = 512,
  parameter int MAP_HEIGHT = 512
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ogb_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ogb_pkg::out_item_t                out_data,
  input  logic                              cfg_en,
  input  logic [ogb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ogb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int XW     = $clog2(MAP_WIDTH);
  localparam int YW     = $clog2(MAP_HEIGHT);
  localparam int ADDR_W = XW + YW;

  ogb_pkg::state_t state, state_next;

  logic [ogb_pkg::WEIGHT_W-1:0] hit_weight;
  logic [ogb_pkg::HALF_W-1:0]   half_width;
  logic [ogb_pkg::HALF_W-1:0]   half_height;

  logic [ogb_pkg::FIELD_W-1:0] last_robot_x;
  logic [ogb_pkg::FIELD_W-1:0] last_robot_y;
  logic                        last_robot_valid;

  logic                        action;
  logic [ogb_pkg::FIELD_W-1:0] hit_x;
  logic [ogb_pkg::FIELD_W-1:0] hit_y;
  logic signed [ogb_pkg::CELL_W-1:0] level;
  logic                        stamped;

  logic [ADDR_W-1:0] clr_addr;

  logic              accept;
  logic              pose_moved;
  ogb_pkg::walk_cmd_t cmd;
  ogb_pkg::walk_pos_t pos;
  logic              on_map;
  logic [ADDR_W-1:0] addr0;

  logic              s1_valid;
  logic              s1_hit;
  logic [ADDR_W-1:0] s1_addr;

  logic                              mem_we;
  logic [ADDR_W-1:0]                 mem_waddr;
  logic [ogb_pkg::CELL_W-1:0]        mem_wdata;
  logic                              mem_re;
  logic [ogb_pkg::CELL_W-1:0]        rd_data;
  logic signed [ogb_pkg::CELL_W:0]   sum;
  logic signed [ogb_pkg::CELL_W-1:0] hit_new;
  logic [ogb_pkg::COORD_W-1:0]       cx;
  logic [ogb_pkg::COORD_W-1:0]       cy;
  logic [ogb_pkg::COORD_W-1:0]       ox;
  logic [ogb_pkg::COORD_W-1:0]       oy;
  logic [ogb_pkg::COORD_W-1:0]       hw;
  logic [ogb_pkg::COORD_W-1:0]       hh;

  assign in_ready = (state == ogb_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_weight  <= ogb_pkg::HIT_WEIGHT_RST;
      half_width  <= ogb_pkg::HALF_RST;
      half_height <= ogb_pkg::HALF_RST;
    end else if (cfg_en) begin
      case (cfg_index)
        ogb_pkg::REG_HIT_WEIGHT:  hit_weight  <= cfg_data[ogb_pkg::WEIGHT_W-1:0];
        ogb_pkg::REG_HALF_WIDTH:  half_width  <= cfg_data[ogb_pkg::HALF_W-1:0];
        ogb_pkg::REG_HALF_HEIGHT: half_height <= cfg_data[ogb_pkg::HALF_W-1:0];
        default: ;
      endcase
    end
  end

  assign pose_moved = !last_robot_valid || (in_data.cell_x != last_robot_x) ||
                      (in_data.cell_y != last_robot_y);

  // Walk bounds: sensor spans hit..origin, pose spans the footprint clipped at zero.
  assign cx = {1'b0, in_data.cell_x};
  assign cy = {1'b0, in_data.cell_y};
  assign ox = {1'b0, in_data.origin_x};
  assign oy = {1'b0, in_data.origin_y};
  assign hw = {{(ogb_pkg::COORD_W-ogb_pkg::HALF_W){1'b0}}, half_width};
  assign hh = {{(ogb_pkg::COORD_W-ogb_pkg::HALF_W){1'b0}}, half_height};

  always_comb begin
    cmd.start = accept && ((in_data.action == ogb_pkg::ACT_SENSOR) || pose_moved);
    if (in_data.action == ogb_pkg::ACT_SENSOR) begin
      cmd.x_lo = (cx < ox) ? cx : ox;
      cmd.x_hi = (cx < ox) ? ox : cx;
      cmd.y_lo = (cy < oy) ? cy : oy;
      cmd.y_hi = (cy < oy) ? oy : cy;
    end else begin
      cmd.x_lo = (cx >= hw) ? cx - hw : '0;
      cmd.x_hi = cx + hw;
      cmd.y_lo = (cy >= hh) ? cy - hh : '0;
      cmd.y_hi = cy + hh;
    end
  end

  ogb_box_walk u_walk (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .pos (pos)
  );

  assign on_map = (32'(pos.x) < MAP_WIDTH) && (32'(pos.y) < MAP_HEIGHT);
  assign addr0  = {YW'(pos.y), XW'(pos.x)};
  assign mem_re = pos.valid && on_map && (action == ogb_pkg::ACT_SENSOR);

  // Item registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_robot_x     <= '0;
      last_robot_y     <= '0;
      last_robot_valid <= 1'b0;
    end else if (accept && (in_data.action == ogb_pkg::ACT_POSE) && pose_moved) begin
      last_robot_x     <= in_data.cell_x;
      last_robot_y     <= in_data.cell_y;
      last_robot_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      action  <= in_data.action;
      hit_x   <= in_data.cell_x;
      hit_y   <= in_data.cell_y;
      level   <= (in_data.action == ogb_pkg::ACT_POSE) ? 8'sd0 : -8'sd1;
      stamped <= (in_data.action == ogb_pkg::ACT_POSE) && pose_moved;
    end else if (s1_valid && s1_hit) begin
      level <= hit_new;
    end
  end

  // Modify stage: read data of the previous cycle's address is in rd_data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= mem_re;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= addr0;
    s1_hit  <= (pos.x == {1'b0, hit_x}) && (pos.y == {1'b0, hit_y});
  end

  assign sum = $signed({rd_data[ogb_pkg::CELL_W-1], rd_data}) +
               $signed({3'b000, hit_weight});

  always_comb begin
    if (rd_data == ogb_pkg::CELL_UNKNOWN) begin
      hit_new = $signed({2'b00, hit_weight});
    end else if (sum > 9'sd127) begin
      hit_new = ogb_pkg::LEVEL_MAX;
    end else begin
      hit_new = sum[ogb_pkg::CELL_W-1:0];
    end
  end

  // Single write port: clearing pass, sensor write-back, footprint stamp.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr0;
    mem_wdata = ogb_pkg::CELL_ROBOT;
    if (state == ogb_pkg::S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = ogb_pkg::CELL_UNKNOWN;
    end else if (s1_valid) begin
      mem_we    = 1'b1;
      mem_waddr = s1_addr;
      if (s1_hit) begin
        mem_wdata = hit_new;
      end else if (rd_data == ogb_pkg::CELL_UNKNOWN) begin
        mem_wdata = ogb_pkg::CELL_FREE;
      end else begin
        mem_wdata = rd_data;
      end
    end else if (pos.valid && on_map && (action == ogb_pkg::ACT_POSE)) begin
      mem_we = 1'b1;
    end
  end

  ogb_cell_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (addr0),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ogb_pkg::S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ogb_pkg::S_CLEAR: if (&clr_addr) state_next = ogb_pkg::S_IDLE;
      ogb_pkg::S_IDLE: begin
        if (accept) begin
          state_next = cmd.start ? ogb_pkg::S_WALK : ogb_pkg::S_DONE;
        end
      end
      ogb_pkg::S_WALK:  if (pos.valid && pos.last) state_next = ogb_pkg::S_DRAIN;
      ogb_pkg::S_DRAIN: state_next = ogb_pkg::S_DONE;
      ogb_pkg::S_DONE:  if (!out_valid || out_ready) state_next = ogb_pkg::S_IDLE;
      default:          state_next = ogb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ogb_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Output register: load when the slot frees, drop after the transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ogb_pkg::S_DONE) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ogb_pkg::S_DONE) && (!out_valid || out_ready)) begin
      out_data.hit_level         <= level;
      out_data.footprint_stamped <= stamped;
    end
  end

endmodule

/* hdl/ogb_cell_mem.sv */
// Evidence cell memory: one write port, one read port, registered read data.
module ogb_cell_mem #(
  parameter int ADDR_W = 18
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ADDR_W-1:0]         waddr,
  input  logic [ogb_pkg::CELL_W-1:0] wdata,
  input  logic                      re,
  input  logic [ADDR_W-1:0]         raddr,
  output logic [ogb_pkg::CELL_W-1:0] rdata
);

  logic [ogb_pkg::CELL_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/ogb_box_walk.sv */
// Box walker: steps through every cell of an inclusive box, y inner, one cell a cycle.
module ogb_box_walk (
  input  logic               clk,
  input  logic               rst,
  input  ogb_pkg::walk_cmd_t cmd,
  output ogb_pkg::walk_pos_t pos
);

  logic                        busy;
  logic [ogb_pkg::COORD_W-1:0] x;
  logic [ogb_pkg::COORD_W-1:0] y;
  logic [ogb_pkg::COORD_W-1:0] x_hi;
  logic [ogb_pkg::COORD_W-1:0] y_lo;
  logic [ogb_pkg::COORD_W-1:0] y_hi;
  logic                        last;

  assign last = (x == x_hi) && (y == y_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.start) begin
      busy <= 1'b1;
    end else if (busy && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x    <= cmd.x_lo;
      y    <= cmd.y_lo;
      x_hi <= cmd.x_hi;
      y_lo <= cmd.y_lo;
      y_hi <= cmd.y_hi;
    end else if (busy) begin
      if (y == y_hi) begin
        y <= y_lo;
        x <= x + 1'b1;
      end else begin
        y <= y + 1'b1;
      end
    end
  end

  assign pos.valid = busy;
  assign pos.last  = last;
  assign pos.x     = x;
  assign pos.y     = y;

endmodule

/* hdl/ogb_checker.sv */
// Port-level assertions for the occupancy grid box update block, with its bind.
module ogb_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ogb_pkg::out_item_t out_data
);

  // The clearing pass keeps the input closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("in_ready high right after reset");

  // One item at a time: an accepted transaction closes the input.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again in the cycle after a transaction");

  // A stamped pose reports no hit level.
  a_pose_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.footprint_stamped) |-> (out_data.hit_level == 8'sd0))
    else $error("stamped pose with nonzero hit level");

  // Levels never drop below unknown.
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.hit_level >= -8'sd1))
    else $error("hit level below unknown");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind occupancy_grid_box_update ogb_checker u_ogb_checker (.*);
